FILE: hdl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared constants and types for the sorted ring membership block.
// ----------------------------------------------------------------------------
package srm_pkg;

	localparam int SLOTS  = 64;
	localparam int ADDR_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int PORT_W = 16;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [PORT_W-1:0] peer_port;
	} req_t;

	typedef struct packed {
		logic [6:0]        member_count;
		logic [PORT_W-1:0] next_port;
		logic [PORT_W-1:0] prev_port;
		logic [1:0]        neighbor_count;
		logic [1:0]        status;
	} resp_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} core_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_sts_t;

endpackage

FILE: hdl/srm_core.sv
// ----------------------------------------------------------------------------
// srm_core
// Port store and request sequencer: scans the sorted store, then shifts
// entries up or down to insert or remove one port.
// ----------------------------------------------------------------------------
module srm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  srm_pkg::core_cmd_t cmd,
	input  srm_pkg::req_t     req,
	output srm_pkg::core_sts_t sts,
	output srm_pkg::resp_t    resp
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q;

	logic [srm_pkg::PORT_W-1:0] mem [srm_pkg::SLOTS];
	logic [srm_pkg::PORT_W-1:0] rd_data_s1;
	logic [srm_pkg::ADDR_W-1:0] rd_addr;
	logic                       we;
	logic [srm_pkg::ADDR_W-1:0] wr_addr;
	logic [srm_pkg::PORT_W-1:0] wr_data;

	logic [srm_pkg::CNT_W-1:0]  count_q;
	logic [1:0]                 kind_q;
	logic [srm_pkg::PORT_W-1:0] port_q;

	logic [srm_pkg::CNT_W-1:0]  iss_q;
	logic                       rv_s1;
	logic [srm_pkg::ADDR_W-1:0] ridx_s1;
	logic [srm_pkg::CNT_W-1:0]  lt_q;
	logic                       found_q;
	logic                       hb_q;
	logic                       ha_q;
	logic [srm_pkg::PORT_W-1:0] below_q;
	logic [srm_pkg::PORT_W-1:0] above_q;
	logic [srm_pkg::PORT_W-1:0] first_q;
	logic [srm_pkg::PORT_W-1:0] last_q;

	logic [srm_pkg::CNT_W-1:0]  dst_q;
	logic                       ins_q;
	logic                       sv_s1;
	logic [srm_pkg::ADDR_W-1:0] sdst_s1;

	logic [1:0]                 status_q;
	logic [1:0]                 nb_q;

	logic                       scan_more;
	logic                       shift_more;
	logic                       put_port;
	logic [srm_pkg::CNT_W-1:0]  dst_m1;
	logic [srm_pkg::CNT_W:0]    dst_p1;

	function automatic logic [1:0] nb_of(input logic [srm_pkg::CNT_W:0] ring);
		logic [1:0] r;
		r = 2'd0;
		if (ring == (srm_pkg::CNT_W+1)'(2))
			r = 2'd1;
		else if (ring > (srm_pkg::CNT_W+1)'(2))
			r = 2'd2;
		return r;
	endfunction

	assign dst_m1     = dst_q - 1'b1;
	assign dst_p1     = {1'b0, dst_q} + 1'b1;
	assign scan_more  = (iss_q < count_q);
	assign shift_more = ins_q ? (dst_q > lt_q) : (dst_p1 < {1'b0, count_q});
	assign put_port   = (state_q == ST_SHIFT) && ins_q && !shift_more && !sv_s1;

	always_comb begin
		rd_addr = iss_q[srm_pkg::ADDR_W-1:0];
		if (state_q == ST_SHIFT) begin
			rd_addr = ins_q ? dst_m1[srm_pkg::ADDR_W-1:0] : dst_p1[srm_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = sdst_s1;
		wr_data = rd_data_s1;
		if (sv_s1) begin
			we = 1'b1;
		end else if (put_port) begin
			we      = 1'b1;
			wr_addr = lt_q[srm_pkg::ADDR_W-1:0];
			wr_data = port_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rv_s1   <= 1'b0;
			sv_s1   <= 1'b0;
		end else begin
			rv_s1 <= 1'b0;
			sv_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rv_s1 <= scan_more;
					if (!scan_more && !rv_s1) begin
						state_q <= ST_FIN;
						if (kind_q == srm_pkg::KIND_INSERT && !found_q
								&& count_q < srm_pkg::CNT_W'(srm_pkg::SLOTS)) begin
							state_q <= ST_SHIFT;
						end else if (kind_q == srm_pkg::KIND_REMOVE && found_q) begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					sv_s1 <= shift_more;
					if (!shift_more && !sv_s1) begin
						count_q <= ins_q ? count_q + 1'b1 : count_q - 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (cmd.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q  <= req.kind;
				port_q  <= req.peer_port;
				iss_q   <= '0;
				lt_q    <= '0;
				found_q <= 1'b0;
				hb_q    <= 1'b0;
				ha_q    <= 1'b0;
			end
			ST_SCAN: begin
				ridx_s1 <= iss_q[srm_pkg::ADDR_W-1:0];
				if (scan_more) begin
					iss_q <= iss_q + 1'b1;
				end
				if (rv_s1) begin
					last_q <= rd_data_s1;
					if (ridx_s1 == '0) begin
						first_q <= rd_data_s1;
					end
					if (rd_data_s1 < port_q) begin
						below_q <= rd_data_s1;
						hb_q    <= 1'b1;
						lt_q    <= lt_q + 1'b1;
					end
					if (rd_data_s1 == port_q) begin
						found_q <= 1'b1;
					end
					if (rd_data_s1 > port_q && !ha_q) begin
						above_q <= rd_data_s1;
						ha_q    <= 1'b1;
					end
				end
				if (!scan_more && !rv_s1) begin
					status_q <= srm_pkg::STATUS_NOTFOUND;
					nb_q     <= 2'd0;
					case (kind_q)
						srm_pkg::KIND_INSERT: begin
							ins_q <= 1'b1;
							dst_q <= count_q;
							if (found_q) begin
								status_q <= srm_pkg::STATUS_OK;
								nb_q     <= nb_of({1'b0, count_q});
							end else if (count_q >= srm_pkg::CNT_W'(srm_pkg::SLOTS)) begin
								status_q <= srm_pkg::STATUS_FULL;
							end else begin
								status_q <= srm_pkg::STATUS_OK;
								nb_q     <= nb_of({1'b0, count_q} + 1'b1);
							end
						end
						srm_pkg::KIND_REMOVE: begin
							ins_q <= 1'b0;
							dst_q <= lt_q;
							if (found_q) begin
								status_q <= srm_pkg::STATUS_OK;
								nb_q     <= nb_of({1'b0, count_q});
							end
						end
						srm_pkg::KIND_QUERY: begin
							if (found_q) begin
								status_q <= srm_pkg::STATUS_OK;
								nb_q     <= nb_of({1'b0, count_q});
							end
						end
						default: begin
							status_q <= srm_pkg::STATUS_NOTFOUND;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				// read one entry, write it to its neighbor slot next cycle
				sdst_s1 <= dst_q[srm_pkg::ADDR_W-1:0];
				if (shift_more) begin
					dst_q <= ins_q ? dst_m1 : dst_p1[srm_pkg::CNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		resp.status         = status_q;
		resp.neighbor_count = nb_q;
		resp.prev_port      = '0;
		resp.next_port      = '0;
		resp.member_count   = 7'(count_q);
		if (nb_q != 2'd0) begin
			resp.prev_port = hb_q ? below_q : last_q;
			resp.next_port = ha_q ? above_q : first_q;
		end
	end

	assign sts.idle = (state_q == ST_IDLE);
	assign sts.done = (state_q == ST_FIN) && cmd.out_free;

endmodule

FILE: hdl/sorted_ring_membership.sv
// ----------------------------------------------------------------------------
// sorted_ring_membership
// Set of distinct port numbers kept as an ascending ring, with neighbor lookup.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser carries the request kind (insert,
// remove, query) and tdata the port. Each request yields exactly one result
// on the m_ stream: status, neighbor count, ring predecessor and successor,
// and the member count after the request.
// One request is worked on at a time. The store is a single-port-read memory
// walked one entry per cycle: a request scans all n members, and an insert
// or remove that changes the set then shifts the entries above its place.
// The result sits in an output register; the next request is taken while
// it waits, and that request holds in its last step until the register is
// free. A stalled receiver thus blocks at most one finished result plus one
// request in flight.
// Reset empties the set; the store contents are left as they are and only
// entries below the member count are ever read.
// ----------------------------------------------------------------------------
module sorted_ring_membership (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] peer_port
	input  logic [1:0]  s_tuser,  // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // [1:0] status, [3:2] neighbor_count,
	                              // [19:4] prev_port, [35:20] next_port,
	                              // [42:36] member_count, [47:43] zero
);

	srm_pkg::core_cmd_t cmd;
	srm_pkg::core_sts_t sts;
	srm_pkg::req_t      req;
	srm_pkg::resp_t     resp;

	logic        m_tvalid_q;
	logic [42:0] m_tdata_q;

	assign req.kind      = s_tuser;
	assign req.peer_port = s_tdata;

	assign s_tready     = sts.idle;
	assign cmd.start    = s_tvalid && sts.idle;
	assign cmd.out_free = !m_tvalid_q || m_tready;

	srm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.resp   (resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (sts.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			m_tdata_q <= resp;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, m_tdata_q};

`ifndef ASSERT_OFF
	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (!m_tvalid_q || m_tready))
		else $error("result produced while output register occupied");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[42:36] <= 7'(srm_pkg::SLOTS)))
		else $error("member count beyond store size");

	a_full_no_neighbors: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == srm_pkg::STATUS_FULL) |-> (m_tdata[3:2] == 2'd0))
		else $error("full status with neighbors reported");
`endif

endmodule
